// File: sv/rrxi_pkg.sv
// rrxi_pkg: types, codes and constants shared by the rotated rectangle xor/invert block
// no dependencies; every other file except rrxi_ram refers to it by scoped names

package rrxi_pkg;

    // request function codes
    localparam logic [1:0] FUNC_WRITE  = 2'd0;
    localparam logic [1:0] FUNC_READ   = 2'd1;
    localparam logic [1:0] FUNC_INVERT = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_PANEL_WIDTH  = 2'd0;
    localparam logic [1:0] REG_PANEL_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ORIENTATION  = 2'd2;

    // orientation codes
    localparam logic [1:0] ORIENT_PORTRAIT  = 2'd0;
    localparam logic [1:0] ORIENT_LAND_CW   = 2'd1;
    localparam logic [1:0] ORIENT_PORT_INV  = 2'd2;
    localparam logic [1:0] ORIENT_LAND_CCW  = 2'd3;

    // register reset values
    localparam logic [10:0] PANEL_WIDTH_RST  = 11'd800;
    localparam logic [9:0]  PANEL_HEIGHT_RST = 10'd480;
    localparam logic [1:0]  ORIENTATION_RST  = ORIENT_PORTRAIT;

    // internal command codes between front and back end
    localparam logic [1:0] CMD_RESULT = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_INVERT = 2'd3;

    // width of the signed rectangle arithmetic
    localparam int CALC_W = 20;

    localparam logic [7:0] FULL_MASK = 8'hFF;

    typedef struct packed {
        logic [1:0]         func;
        logic [15:0]        byte_addr;
        logic [7:0]         write_data;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic signed [15:0] rect_w;
        logic signed [15:0] rect_h;
    } in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       status;
    } out_t;

    typedef struct packed {
        logic [10:0] panel_width;
        logic [9:0]  panel_height;
        logic [1:0]  orientation;
    } cfg_t;

    // one classified request for the back end
    typedef struct packed {
        logic [1:0]  code;
        logic        status;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [7:0]  first_byte;
        logic [7:0]  last_byte;
        logic [7:0]  first_mask;
        logic [7:0]  last_mask;
        logic [9:0]  row_first;
        logic [9:0]  row_last;
        logic [7:0]  stride;
    } cmd_t;

endpackage

// File: sv/rrxi_ram.sv
// rrxi_ram: generic single-write, single-read ram with registered read data
// no dependencies

module rrxi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/rrxi_front.sv
// rrxi_front: accepts request items, maps and clips rectangles, emits commands
// depends on rrxi_pkg

module rrxi_front #(
    parameter int FRAME_BYTES = 65536
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  rrxi_pkg::cfg_t   cfg,
    input  logic             s_valid,
    output logic             s_ready,
    input  rrxi_pkg::in_t    s_payload,
    output logic             push_valid,
    input  logic             push_ready,
    output rrxi_pkg::cmd_t   push_cmd
);

    localparam int CW = rrxi_pkg::CALC_W;

    localparam logic [2:0] FS_IDLE = 3'd0;
    localparam logic [2:0] FS_C1   = 3'd1;
    localparam logic [2:0] FS_C2   = 3'd2;
    localparam logic [2:0] FS_C3   = 3'd3;
    localparam logic [2:0] FS_C4   = 3'd4;

    logic [2:0]           state_reg, state_next;
    rrxi_pkg::in_t        in_reg;
    logic signed [CW-1:0] lx1_reg, ly1_reg;
    logic                 setup_ok_reg, empty_reg;
    logic signed [CW-1:0] x0_reg, x1_reg, y0_reg, y1_reg;
    logic signed [CW-1:0] x0c_reg, x1c_reg, y0c_reg, y1c_reg;

    logic [7:0]           stride;
    logic [17:0]          frame_prod;
    logic signed [CW-1:0] wm1, hm1;
    logic signed [CW-1:0] ext_x, ext_y;
    logic                 addr_ok, skip;

    assign stride     = cfg.panel_width[10:3];
    assign frame_prod = {10'd0, stride} * {8'd0, cfg.panel_height};
    assign wm1   = signed'(CW'(cfg.panel_width)) - CW'(1);
    assign hm1   = signed'(CW'(cfg.panel_height)) - CW'(1);
    assign ext_x = CW'(in_reg.rect_x);
    assign ext_y = CW'(in_reg.rect_y);

    assign s_ready    = (state_reg == FS_IDLE);
    assign push_valid = (state_reg == FS_C4);

    // sequencing through the classification steps
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FS_IDLE: if (s_valid) state_next = FS_C1;
            FS_C1:   state_next = FS_C2;
            FS_C2:   state_next = FS_C3;
            FS_C3:   state_next = FS_C4;
            FS_C4:   if (push_ready) state_next = FS_IDLE;
            default: state_next = FS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // capture the item and run the rectangle arithmetic
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_payload;
        end
        // step 1: far corners, setup and empty checks
        if (state_reg == FS_C1) begin
            lx1_reg      <= ext_x + CW'(in_reg.rect_w) - CW'(1);
            ly1_reg      <= ext_y + CW'(in_reg.rect_h) - CW'(1);
            setup_ok_reg <= (cfg.panel_width != 11'd0) && (cfg.panel_width[2:0] == 3'd0)
                && (cfg.panel_height != 10'd0)
                && (32'(frame_prod) <= 32'(FRAME_BYTES));
            empty_reg    <= (in_reg.rect_w <= 16'sd0) || (in_reg.rect_h <= 16'sd0);
        end
        // step 2: logical to panel coordinates
        if (state_reg == FS_C2) begin
            case (cfg.orientation)
                rrxi_pkg::ORIENT_PORTRAIT: begin
                    x0_reg <= ext_y;
                    x1_reg <= ly1_reg;
                    y0_reg <= hm1 - lx1_reg;
                    y1_reg <= hm1 - ext_x;
                end
                rrxi_pkg::ORIENT_LAND_CW: begin
                    x0_reg <= wm1 - lx1_reg;
                    x1_reg <= wm1 - ext_x;
                    y0_reg <= hm1 - ly1_reg;
                    y1_reg <= hm1 - ext_y;
                end
                rrxi_pkg::ORIENT_PORT_INV: begin
                    x0_reg <= wm1 - ly1_reg;
                    x1_reg <= wm1 - ext_y;
                    y0_reg <= ext_x;
                    y1_reg <= lx1_reg;
                end
                default: begin
                    x0_reg <= ext_x;
                    x1_reg <= lx1_reg;
                    y0_reg <= ext_y;
                    y1_reg <= ly1_reg;
                end
            endcase
        end
        // step 3: clip to the panel
        if (state_reg == FS_C3) begin
            x0c_reg <= x0_reg[CW-1] ? '0 : x0_reg;
            y0c_reg <= y0_reg[CW-1] ? '0 : y0_reg;
            x1c_reg <= (x1_reg > wm1) ? wm1 : x1_reg;
            y1c_reg <= (y1_reg > hm1) ? hm1 : y1_reg;
        end
    end

    // step 4: build the command
    assign addr_ok = (32'(in_reg.byte_addr) < 32'(FRAME_BYTES));
    assign skip    = !setup_ok_reg || empty_reg || (x0c_reg > x1c_reg)
                     || (y0c_reg > y1c_reg);

    always_comb begin
        push_cmd            = '0;
        push_cmd.code       = rrxi_pkg::CMD_RESULT;
        push_cmd.addr       = in_reg.byte_addr;
        push_cmd.data       = in_reg.write_data;
        push_cmd.first_byte = x0c_reg[10:3];
        push_cmd.last_byte  = x1c_reg[10:3];
        push_cmd.first_mask = rrxi_pkg::FULL_MASK >> x0c_reg[2:0];
        push_cmd.last_mask  = rrxi_pkg::FULL_MASK << (3'd7 - x1c_reg[2:0]);
        push_cmd.row_first  = y0c_reg[9:0];
        push_cmd.row_last   = y1c_reg[9:0];
        push_cmd.stride     = stride;
        case (in_reg.func)
            rrxi_pkg::FUNC_WRITE: if (addr_ok) push_cmd.code = rrxi_pkg::CMD_WRITE;
            rrxi_pkg::FUNC_READ:  if (addr_ok) push_cmd.code = rrxi_pkg::CMD_READ;
            rrxi_pkg::FUNC_INVERT: begin
                if (skip) begin
                    push_cmd.status = 1'b1;
                end else begin
                    push_cmd.code = rrxi_pkg::CMD_INVERT;
                end
            end
            default: push_cmd.code = rrxi_pkg::CMD_RESULT;
        endcase
    end

endmodule

// File: sv/rrxi_queue.sv
// rrxi_queue: two-entry command queue between front and back end
// depends on rrxi_pkg

module rrxi_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  rrxi_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output rrxi_pkg::cmd_t pop_cmd
);

    rrxi_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)  rd_ptr_reg <= ~rd_ptr_reg;
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// File: sv/rrxi_back.sv
// rrxi_back: executes commands on the frame memory and holds the result item
// depends on rrxi_pkg and rrxi_ram

module rrxi_back #(
    parameter int FRAME_BYTES = 65536
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  rrxi_pkg::cmd_t pop_cmd,
    output logic           m_valid,
    input  logic           m_ready,
    output rrxi_pkg::out_t m_payload
);

    localparam int AW = $clog2(FRAME_BYTES);

    localparam logic [2:0] BS_IDLE  = 3'd0;
    localparam logic [2:0] BS_READ  = 3'd1;
    localparam logic [2:0] BS_SETUP = 3'd2;
    localparam logic [2:0] BS_RUN   = 3'd3;
    localparam logic [2:0] BS_DRAIN = 3'd4;
    localparam logic [2:0] BS_DONE  = 3'd5;

    logic [2:0]     state_reg, state_next;
    rrxi_pkg::cmd_t cmd_reg, cmd_next;
    logic [AW-1:0]  base_reg, base_next;
    logic [7:0]     byte_reg, byte_next;
    logic [9:0]     row_reg, row_next;
    logic           rmw_valid_reg, rmw_valid_next;
    logic [AW-1:0]  rmw_addr_reg, rmw_addr_next;
    logic [7:0]     rmw_mask_reg, rmw_mask_next;
    rrxi_pkg::out_t res_reg, res_next;
    logic           m_valid_reg, m_valid_next;
    rrxi_pkg::out_t m_data_reg, m_data_next;

    logic           ram_we, ram_re;
    logic [AW-1:0]  ram_waddr, ram_raddr, run_addr;
    logic [7:0]     ram_wdata, ram_rdata, byte_mask;
    logic [17:0]    row_prod;
    logic           take, out_free;

    rrxi_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pop_ready = (state_reg == BS_IDLE);
    assign take      = pop_valid && pop_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign row_prod  = {8'd0, cmd_reg.row_first} * {10'd0, cmd_reg.stride};
    assign run_addr  = base_reg + AW'(byte_reg);

    // edge masks for the byte being walked
    always_comb begin
        if (cmd_reg.first_byte == cmd_reg.last_byte) begin
            byte_mask = cmd_reg.first_mask & cmd_reg.last_mask;
        end else if (byte_reg == cmd_reg.first_byte) begin
            byte_mask = cmd_reg.first_mask;
        end else if (byte_reg == cmd_reg.last_byte) begin
            byte_mask = cmd_reg.last_mask;
        end else begin
            byte_mask = rrxi_pkg::FULL_MASK;
        end
    end

    // memory ports: plain write or read-modify-write write-back, and the read port
    always_comb begin
        ram_we    = rmw_valid_reg;
        ram_waddr = rmw_addr_reg;
        ram_wdata = ram_rdata ^ rmw_mask_reg;
        if (take && (pop_cmd.code == rrxi_pkg::CMD_WRITE)) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(pop_cmd.addr);
            ram_wdata = pop_cmd.data;
        end
        ram_re    = (state_reg == BS_RUN) || (take && (pop_cmd.code == rrxi_pkg::CMD_READ));
        ram_raddr = (state_reg == BS_RUN) ? run_addr : AW'(pop_cmd.addr);
    end

    // command sequencer
    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        base_next      = base_reg;
        byte_next      = byte_reg;
        row_next       = row_reg;
        rmw_valid_next = 1'b0;
        rmw_addr_next  = rmw_addr_reg;
        rmw_mask_next  = rmw_mask_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        case (state_reg)
            BS_IDLE: begin
                if (take) begin
                    cmd_next = pop_cmd;
                    res_next = '{read_data: 8'd0, status: pop_cmd.status};
                    case (pop_cmd.code)
                        rrxi_pkg::CMD_READ:   state_next = BS_READ;
                        rrxi_pkg::CMD_INVERT: state_next = BS_SETUP;
                        default:              state_next = BS_DONE;
                    endcase
                end
            end
            BS_READ: begin
                res_next   = '{read_data: ram_rdata, status: 1'b0};
                state_next = BS_DONE;
            end
            BS_SETUP: begin
                base_next  = AW'(row_prod);
                byte_next  = cmd_reg.first_byte;
                row_next   = cmd_reg.row_first;
                state_next = BS_RUN;
            end
            BS_RUN: begin
                rmw_valid_next = 1'b1;
                rmw_addr_next  = run_addr;
                rmw_mask_next  = byte_mask;
                if (byte_reg == cmd_reg.last_byte) begin
                    if (row_reg == cmd_reg.row_last) begin
                        state_next = BS_DRAIN;
                    end else begin
                        row_next  = row_reg + 10'd1;
                        base_next = base_reg + AW'(cmd_reg.stride);
                        byte_next = cmd_reg.first_byte;
                    end
                end else begin
                    byte_next = byte_reg + 8'd1;
                end
            end
            BS_DRAIN: state_next = BS_DONE;
            BS_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = BS_IDLE;
                end
            end
            default: state_next = BS_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BS_IDLE;
            rmw_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rmw_valid_reg <= rmw_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        base_reg     <= base_next;
        byte_reg     <= byte_next;
        row_reg      <= row_next;
        rmw_addr_reg <= rmw_addr_next;
        rmw_mask_reg <= rmw_mask_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

endmodule

// File: sv/rotated_rect_xor_invert.sv
// rotated_rect_xor_invert: top level, configuration registers, front end, queue, back end
// depends on rrxi_pkg, rrxi_front, rrxi_queue, rrxi_back
// the front end takes no new item until it has handed the last one to the queue; an
// invert holds the back end while it walks each byte of its clipped rows; reset
// clears control state, sets 800 / 480 / portrait and leaves the frame memory
// contents untouched

module rotated_rect_xor_invert #(
    parameter int FRAME_BYTES = 65536
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [10:0]    cfg_data,
    input  logic           s_valid,
    output logic           s_ready,
    input  rrxi_pkg::in_t  s_payload,
    output logic           m_valid,
    input  logic           m_ready,
    output rrxi_pkg::out_t m_payload
);

    rrxi_pkg::cfg_t cfg_reg;
    logic           push_valid, push_ready, pop_valid, pop_ready;
    rrxi_pkg::cmd_t push_cmd, pop_cmd;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.panel_width  <= rrxi_pkg::PANEL_WIDTH_RST;
            cfg_reg.panel_height <= rrxi_pkg::PANEL_HEIGHT_RST;
            cfg_reg.orientation  <= rrxi_pkg::ORIENTATION_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                rrxi_pkg::REG_PANEL_WIDTH:  cfg_reg.panel_width  <= cfg_data;
                rrxi_pkg::REG_PANEL_HEIGHT: cfg_reg.panel_height <= cfg_data[9:0];
                rrxi_pkg::REG_ORIENTATION:  cfg_reg.orientation  <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // classification
    rrxi_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // decoupling queue
    rrxi_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // execution on the frame memory
    rrxi_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

// File: bench/rotated_rect_xor_invert_tb.sv
`timescale 1ns / 1ps
// rotated_rect_xor_invert_tb: self-checking bench for the rotated rectangle xor/invert block
// depends on rrxi_pkg and rotated_rect_xor_invert; keeps its own frame copy and panel setup

module rotated_rect_xor_invert_tb;

    localparam int FRAME_BYTES   = 65536;
    localparam int PREFILL_BYTES = 256;
    localparam int RANDOM_ITEMS  = 804;
    localparam int RANDOM_PHASES = 12;
    localparam int SETTLE_CYCLES = 20;
    localparam int QUIET_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 40;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic            aclk      = 1'b0;
    logic            aresetn   = 1'b0;
    logic            cfg_we    = 1'b0;
    logic [1:0]      cfg_index = '0;
    logic [10:0]     cfg_data  = '0;
    logic            s_valid   = 1'b0;
    logic            s_ready;
    rrxi_pkg::in_t   s_payload = '0;
    logic            m_valid;
    logic            m_ready   = 1'b0;
    rrxi_pkg::out_t  m_payload;

    // predicted panel setup and frame contents
    logic [10:0]     panel_w      = rrxi_pkg::PANEL_WIDTH_RST;
    logic [9:0]      panel_h      = rrxi_pkg::PANEL_HEIGHT_RST;
    logic [1:0]      panel_orient = rrxi_pkg::ORIENTATION_RST;
    logic [7:0]      frame_copy [FRAME_BYTES];
    bit              frame_written [FRAME_BYTES];
    int              written_addrs [$];
    rrxi_pkg::out_t  pending_results [$];

    // traffic shaping and bookkeeping
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int error_count    = 0;
    int quiet_cycles   = 0;

    always #6 aclk = ~aclk;

    rotated_rect_xor_invert #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    // panel setup usable for an invert
    function automatic bit panel_ok();
        int pw, ph;
        pw = int'(panel_w);
        ph = int'(panel_h);
        return pw != 0 && ph != 0 && pw % 8 == 0 && (pw / 8) * ph <= FRAME_BYTES;
    endfunction

    // clipped panel window of a logical rectangle, returns 1 when the invert is skipped
    function automatic bit invert_window(input int rx, input int ry, input int rw, input int rh,
                                         output int x0, output int x1,
                                         output int y0, output int y1);
        int pw, ph, lx1, ly1;
        pw = int'(panel_w);
        ph = int'(panel_h);
        x0 = 0;
        x1 = -1;
        y0 = 0;
        y1 = -1;
        if (!panel_ok() || rw <= 0 || rh <= 0) begin
            return 1'b1;
        end
        lx1 = rx + rw - 1;
        ly1 = ry + rh - 1;
        case (panel_orient)
            rrxi_pkg::ORIENT_PORTRAIT: begin
                x0 = ry;          x1 = ly1;
                y0 = ph - 1 - lx1; y1 = ph - 1 - rx;
            end
            rrxi_pkg::ORIENT_LAND_CW: begin
                x0 = pw - 1 - lx1; x1 = pw - 1 - rx;
                y0 = ph - 1 - ly1; y1 = ph - 1 - ry;
            end
            rrxi_pkg::ORIENT_PORT_INV: begin
                x0 = pw - 1 - ly1; x1 = pw - 1 - ry;
                y0 = rx;          y1 = lx1;
            end
            default: begin
                x0 = rx; x1 = lx1;
                y0 = ry; y1 = ly1;
            end
        endcase
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > pw - 1) x1 = pw - 1;
        if (y1 > ph - 1) y1 = ph - 1;
        return x0 > x1 || y0 > y1;
    endfunction

    // every byte under the window holds written data
    function automatic bit window_written(input int x0, input int x1, input int y0, input int y1);
        int stride, y, b;
        stride = int'(panel_w) / 8;
        for (y = y0; y <= y1; y++) begin
            for (b = x0 / 8; b <= x1 / 8; b++) begin
                if (!frame_written[y * stride + b]) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // xor the window into the frame copy, msb is the leftmost pixel
    function automatic void apply_invert(input int x0, input int x1, input int y0, input int y1);
        int stride, first_byte, last_byte, row_base, y, b;
        logic [7:0] first_mask, last_mask;
        stride     = int'(panel_w) / 8;
        first_byte = x0 / 8;
        last_byte  = x1 / 8;
        first_mask = rrxi_pkg::FULL_MASK >> (x0 % 8);
        last_mask  = rrxi_pkg::FULL_MASK << (7 - x1 % 8);
        for (y = y0; y <= y1; y++) begin
            row_base = y * stride;
            if (first_byte == last_byte) begin
                frame_copy[row_base + first_byte] ^= first_mask & last_mask;
            end else begin
                frame_copy[row_base + first_byte] ^= first_mask;
                for (b = first_byte + 1; b < last_byte; b++) begin
                    frame_copy[row_base + b] ^= rrxi_pkg::FULL_MASK;
                end
                frame_copy[row_base + last_byte] ^= last_mask;
            end
        end
    endfunction

    // expected result of one accepted item, frame copy updated on the way
    function automatic void predict_request(input rrxi_pkg::in_t item);
        rrxi_pkg::out_t want;
        int x0, x1, y0, y1;
        want = '0;
        case (item.func)
            rrxi_pkg::FUNC_WRITE: begin
                frame_copy[item.byte_addr]    = item.write_data;
                frame_written[item.byte_addr] = 1'b1;
                written_addrs.insert(written_addrs.size(), int'(item.byte_addr));
            end
            rrxi_pkg::FUNC_READ: begin
                want.read_data = frame_copy[item.byte_addr];
            end
            rrxi_pkg::FUNC_INVERT: begin
                want.status = invert_window(int'(item.rect_x), int'(item.rect_y),
                                            int'(item.rect_w), int'(item.rect_h),
                                            x0, x1, y0, y1);
                if (!want.status) apply_invert(x0, x1, y0, y1);
            end
            default: ;
        endcase
        pending_results.insert(pending_results.size(), want);
    endfunction

    // write or read item with noise in the unused fields
    function automatic rrxi_pkg::in_t make_access(input logic [1:0] func,
                                                  input logic [15:0] addr,
                                                  input logic [7:0] data);
        rrxi_pkg::in_t item;
        item.func       = func;
        item.byte_addr  = addr;
        item.write_data = data;
        item.rect_x     = 16'($urandom);
        item.rect_y     = 16'($urandom);
        item.rect_w     = 16'($urandom);
        item.rect_h     = 16'($urandom);
        return item;
    endfunction

    // logical rectangle that lands on a given panel box under the current orientation
    function automatic rrxi_pkg::in_t box_to_rect(input int px0, input int px1,
                                                  input int py0, input int py1);
        rrxi_pkg::in_t item;
        int pw, ph, bw, bh;
        pw = int'(panel_w);
        ph = int'(panel_h);
        bw = px1 - px0 + 1;
        bh = py1 - py0 + 1;
        item = make_access(rrxi_pkg::FUNC_INVERT, 16'($urandom), 8'($urandom));
        case (panel_orient)
            rrxi_pkg::ORIENT_PORTRAIT: begin
                item.rect_x = 16'(ph - 1 - py1); item.rect_w = 16'(bh);
                item.rect_y = 16'(px0);          item.rect_h = 16'(bw);
            end
            rrxi_pkg::ORIENT_LAND_CW: begin
                item.rect_x = 16'(pw - 1 - px1); item.rect_w = 16'(bw);
                item.rect_y = 16'(ph - 1 - py1); item.rect_h = 16'(bh);
            end
            rrxi_pkg::ORIENT_PORT_INV: begin
                item.rect_x = 16'(py0);          item.rect_w = 16'(bh);
                item.rect_y = 16'(pw - 1 - px1); item.rect_h = 16'(bw);
            end
            default: begin
                item.rect_x = 16'(px0); item.rect_w = 16'(bw);
                item.rect_y = 16'(py0); item.rect_h = 16'(bh);
            end
        endcase
        return item;
    endfunction

    // an invert that would touch unwritten frame bytes becomes an empty rectangle
    function automatic rrxi_pkg::in_t keep_to_written(input rrxi_pkg::in_t item);
        int x0, x1, y0, y1;
        bit skipped;
        if (item.func == rrxi_pkg::FUNC_INVERT) begin
            skipped = invert_window(int'(item.rect_x), int'(item.rect_y),
                                    int'(item.rect_w), int'(item.rect_h), x0, x1, y0, y1);
            if (!skipped && !window_written(x0, x1, y0, y1)) begin
                item.rect_w = 16'(-int'($urandom_range(0, 32768)));
            end
        end
        return item;
    endfunction

    // box inside the prefilled rows, sometimes hanging over the panel edges
    function automatic rrxi_pkg::in_t random_box_invert();
        int pw, ph, rows_ok, px0, px1, py0, py1, span;
        pw      = int'(panel_w);
        ph      = int'(panel_h);
        rows_ok = PREFILL_BYTES / (pw / 8);
        if (rows_ok > ph) rows_ok = ph;
        px0  = int'($urandom_range(0, pw - 1));
        span = pw - 1 - px0;
        if ($urandom_range(1) == 0 && span > 12) span = 12;
        px1  = px0 + int'($urandom_range(0, span));
        py0  = int'($urandom_range(0, rows_ok - 1));
        span = rows_ok - 1 - py0;
        if (span > 15) span = 15;
        py1  = py0 + int'($urandom_range(0, span));
        if ($urandom_range(3) == 0) px0 -= int'($urandom_range(1, 40));
        if ($urandom_range(3) == 0) px1 += int'($urandom_range(1, 40));
        if ($urandom_range(3) == 0) py0 -= int'($urandom_range(1, 40));
        if (rows_ok == ph && $urandom_range(3) == 0) py1 += int'($urandom_range(1, 40));
        return box_to_rect(px0, px1, py0, py1);
    endfunction

    // mixed random traffic: accesses, shaped inverts, raw inverts, unused code
    function automatic rrxi_pkg::in_t random_item();
        rrxi_pkg::in_t item;
        int pick;
        item = make_access(FUNC_UNUSED, 16'($urandom), 8'($urandom));
        pick = int'($urandom_range(0, 99));
        if (pick < 22) begin
            item.func = rrxi_pkg::FUNC_WRITE;
            if ($urandom_range(9) < 7) item.byte_addr = 16'($urandom_range(0, PREFILL_BYTES - 1));
        end else if (pick < 44) begin
            item.func      = rrxi_pkg::FUNC_READ;
            item.byte_addr = 16'(written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
        end else if (pick < 49) begin
            item.func = FUNC_UNUSED;
        end else if (pick < 89 && panel_ok()) begin
            item = random_box_invert();
        end else begin
            item.func = rrxi_pkg::FUNC_INVERT;
        end
        return keep_to_written(item);
    endfunction

    // panel setup for a random phase, the first few are the extremes
    function automatic void choose_panel(input int phase, output logic [10:0] w,
                                         output logic [9:0] h);
        int stride, rows;
        case (phase)
            0: begin w = 11'd8;    h = 10'd1;    end
            1: begin w = 11'd8;    h = 10'd1023; end
            2: begin w = 11'd1024; h = 10'd512;  end
            3: begin w = 11'd2040; h = 10'd257;  end
            4: begin w = 11'd2047; h = 10'd10;   end
            default: begin
                stride = int'($urandom_range(1, 16));
                rows   = PREFILL_BYTES / stride;
                if (rows > 64) rows = 64;
                w = 11'(8 * stride);
                h = 10'($urandom_range(1, rows));
                if ($urandom_range(4) == 0) begin
                    w = 11'(8 * stride + int'($urandom_range(1, 7)));
                end else if ($urandom_range(4) == 0) begin
                    w = 11'(8 * int'($urandom_range(17, 128)));
                    h = 10'($urandom_range(1, 511));
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, got %0h expected %0h", $realtime, what, got, want);
        end
    endtask

    // offer one item and wait for it to be taken
    task automatic send_item(input rrxi_pkg::in_t item);
        @(negedge aclk);
        while (int'($urandom_range(0, 99)) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_payload = item;
        do @(posedge aclk); while (!s_ready);
        predict_request(item);
    endtask

    // stop offering and let every expected result come back
    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [10:0] data);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (index)
            rrxi_pkg::REG_PANEL_WIDTH:  panel_w      = data;
            rrxi_pkg::REG_PANEL_HEIGHT: panel_h      = data[9:0];
            rrxi_pkg::REG_ORIENTATION:  panel_orient = data[1:0];
            default: ;
        endcase
    endtask

    // unused upper bits of the narrow registers carry noise
    task automatic set_panel(input logic [10:0] w, input logic [9:0] h, input logic [1:0] orient);
        wait_idle();
        write_register(rrxi_pkg::REG_PANEL_WIDTH, w);
        write_register(rrxi_pkg::REG_PANEL_HEIGHT, {1'($urandom_range(1)), h});
        write_register(rrxi_pkg::REG_ORIENTATION, {9'($urandom), orient});
    endtask

    // receiver: long hold-off when asked, otherwise random stalls
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else begin
            m_ready = int'($urandom_range(0, 99)) >= recv_stall_pct;
        end
    end

    // compare each result with the oldest prediction
    always @(posedge aclk) begin : result_check
        rrxi_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, read_data", m_payload.read_data, 8'h00);
            end else begin
                want = pending_results.pop_front();
                if (m_payload.read_data !== want.read_data) begin
                    report_mismatch("read_data", m_payload.read_data, want.read_data);
                end
                if (m_payload.status !== want.status) begin
                    report_mismatch("status", 8'(m_payload.status), 8'(want.status));
                end
            end
        end
    end

    // no item moving on either side for too long ends the run
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // the frame memory is undefined after reset, so write a known prefix first
    task automatic test_prefill();
        int i;
        for (i = 0; i < PREFILL_BYTES; i++) begin
            send_item(make_access(rrxi_pkg::FUNC_WRITE, 16'(i), 8'($urandom)));
        end
    endtask

    // lowest and highest addresses and data, unused function code
    task automatic test_access_extremes();
        rrxi_pkg::in_t item;
        send_item(make_access(rrxi_pkg::FUNC_WRITE, 16'hFFFF, 8'hFF));
        send_item(make_access(rrxi_pkg::FUNC_WRITE, 16'h0000, 8'h00));
        send_item(make_access(rrxi_pkg::FUNC_WRITE, 16'h8000, 8'hA5));
        send_item(make_access(rrxi_pkg::FUNC_READ, 16'hFFFF, 8'h00));
        send_item(make_access(rrxi_pkg::FUNC_READ, 16'h8000, 8'hFF));
        item = '1;
        item.func = FUNC_UNUSED;
        send_item(item);
        item = '0;
        item.func = FUNC_UNUSED;
        send_item(item);
    endtask

    // default panel: single byte, edge clipping, empty and clipped-away rectangles
    task automatic test_invert_special_cases();
        rrxi_pkg::in_t item;
        send_item(box_to_rect(3, 5, 1, 1));
        send_item(box_to_rect(-5, 20, -3, 2));
        send_item(box_to_rect(790, 830, 0, 1));
        item = box_to_rect(0, 7, 0, 0);
        item.rect_w = 16'sd0;
        send_item(item);
        item.rect_w = 16'sh8000;
        send_item(item);
        item.rect_w = 16'sd8;
        item.rect_h = -16'sd1;
        send_item(item);
        item.rect_x = 16'sh7FFF;
        item.rect_y = 16'sh0000;
        item.rect_w = 16'sh7FFF;
        item.rect_h = 16'sh7FFF;
        send_item(item);
        item.rect_x = 16'sh8000;
        item.rect_y = 16'sh8000;
        send_item(item);
        send_item(make_access(rrxi_pkg::FUNC_READ, 16'd0, 8'h00));
        send_item(make_access(rrxi_pkg::FUNC_READ, 16'd100, 8'h00));
    endtask

    // zero width, width not a multiple of eight, zero height, frame too small
    task automatic test_invalid_setup();
        set_panel(11'd0, 10'd480, rrxi_pkg::ORIENT_PORTRAIT);
        send_item(box_to_rect(0, 7, 0, 0));
        set_panel(11'd12, 10'd100, rrxi_pkg::ORIENT_LAND_CW);
        send_item(box_to_rect(0, 7, 0, 0));
        set_panel(11'd64, 10'd0, rrxi_pkg::ORIENT_PORT_INV);
        send_item(box_to_rect(0, 7, 0, 0));
        set_panel(11'd2040, 10'd300, rrxi_pkg::ORIENT_LAND_CCW);
        send_item(box_to_rect(0, 7, 0, 0));
    endtask

    // same panel box through each orientation, read back a partly masked byte
    task automatic test_orientations();
        int o;
        for (o = 0; o < 4; o++) begin
            set_panel(11'd64, 10'd16, 2'(o));
            send_item(box_to_rect(-3, 37, 5, 19));
            send_item(make_access(rrxi_pkg::FUNC_READ, 16'd44, 8'h00));
        end
    endtask

    // receiver holds off while items keep coming, so the block fills and stalls
    task automatic test_backpressure();
        set_panel(11'd64, 10'd16, rrxi_pkg::ORIENT_LAND_CCW);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge aclk);
        hold_left = HOLD_CYCLES;
        repeat (80) send_item(random_item());
    endtask

    // random traffic over several panel setups and idle patterns
    task automatic test_random_traffic();
        int phase;
        logic [10:0] w;
        logic [9:0] h;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            choose_panel(phase, w, h);
            set_panel(w, h, 2'((phase + phase / 4) % 4));
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            repeat (RANDOM_ITEMS / RANDOM_PHASES) send_item(random_item());
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_prefill();
        test_access_extremes();
        test_invert_special_cases();
        test_invalid_setup();
        test_orientations();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
